// File: src/fee_pkg.sv
// Shared types, constants and helpers for the two-page EEPROM emulation core.
// No dependencies.
package fee_pkg;

  localparam int unsigned SLOTS    = 256;
  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam int unsigned NS_W     = SLOT_W + 1;
  localparam int unsigned ADDR_W   = SLOT_W + 1;
  localparam int unsigned NUM_KEYS = 2;

  localparam logic [15:0] HDR_ERASED = 16'hFFFF;
  localparam logic [15:0] HDR_XFER   = 16'h1234;
  localparam logic [15:0] HDR_VALID  = 16'h0000;
  localparam logic [31:0] WORD_EMPTY = 32'hFFFF_FFFF;
  localparam logic [15:0] KEY0_RST   = 16'h1000;
  localparam logic [15:0] KEY1_RST   = 16'h2000;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_MOUNT = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  typedef enum logic {
    CFG_KEY_0 = 1'b0,
    CFG_KEY_1 = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KSEL_REQ,
    KSEL_K0,
    KSEL_K1
  } key_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RD_WAIT,
    ST_W_RD,
    ST_W_WR,
    ST_W_CHK,
    ST_X_INIT,
    ST_X_FE_WAIT,
    ST_X_HDR,
    ST_X_LK,
    ST_X_LK_WAIT,
    ST_X_P_RD,
    ST_X_P_WR,
    ST_X_ERASE,
    ST_X_VALID,
    ST_M_CASE,
    ST_M_FMT,
    ST_M_HDR,
    ST_M_TAIL,
    ST_M_FE_WAIT,
    ST_M_CHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] virt_key;
    logic [15:0] write_value;
  } req_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic        found;
    logic        store_ready;
  } rsp_t;

  typedef struct packed {
    logic        accept;
    logic        scan_start;
    logic        scan_fe;
    logic        scan_page;
    key_sel_e    key_sel;
    logic        prog_rd;
    logic        prog_wr;
    logic        prog_page;
    logic        hdr_we;
    logic        hdr_page;
    logic [15:0] hdr_val;
    logic        erase;
    logic        erase_page;
    logic        ns_clear;
    logic        emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] hdr_a;
    logic [15:0] hdr_b;
    logic        scan_done;
    logic        scan_hit;
    logic        ns_full;
    logic        ns_zero;
  } sts_t;

  // exactly one page valid
  function automatic logic vp_exists(input logic [15:0] ha, input logic [15:0] hb);
    return (ha == HDR_VALID) != (hb == HDR_VALID);
  endfunction

  function automatic logic vp_page(input logic [15:0] ha, input logic [15:0] hb);
    return (ha != HDR_VALID) && (hb == HDR_VALID);
  endfunction

endpackage

// File: src/flash_eeprom_emulator_core.sv
// Top level of the two-page EEPROM emulation core: controller plus datapath.
// Depends on fee_pkg, fee_ctrl, fee_datapath (and fee_store below it).
//
//   channel   | handshake            | payload
//   ----------+----------------------+-------------------------------------
//   request   | start & !busy        | req_i  (req_type, virt_key, write_value)
//   result    | done_o, one cycle    | rsp_o  (read_value, found, store_ready)
//   config    | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// One item at a time. The slot scanner addresses a slot and then compares it, one slot
// after another, on the single RAM read port; a write that fills the page adds a
// transfer (free-slot scan plus one lookup per kept key), and a mount up to two transfers.
// Reset leaves both pages erased at once (per-page fill counts clear); no clearing pass.
// The result strobe cannot be held off; busy is already low in the strobe cycle.
module flash_eeprom_emulator_core import fee_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  fee_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  fee_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .done_o    (done_o),
    .rsp_o     (rsp_o)
  );

endmodule

// File: src/fee_store.sv
// Slot store for both pages: one RAM plus a fill count per page (words at or above it read erased).
// Depends on fee_pkg.
module fee_store import fee_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [31:0]       rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [31:0]       wr_data_i,
  input  logic              erase_i,
  input  logic              erase_page_i
);

  logic [31:0]           mem [2*SLOTS];
  logic [1:0][NS_W-1:0]  fill_q;
  logic [31:0]           rd_word_q;
  logic                  rd_vld_q;
  logic [NS_W-1:0]       rd_idx, wr_idx;

  // slots are programmed in ascending order, so one high-water mark per page suffices
  assign rd_idx = {1'b0, rd_addr_i[SLOT_W-1:0]};
  assign wr_idx = {1'b0, wr_addr_i[SLOT_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_word_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_vld_q <= (rd_idx < fill_q[rd_addr_i[SLOT_W]]);
      end
      if (erase_i) begin
        fill_q[erase_page_i] <= '0;
      end else if (wr_en_i && (wr_idx >= fill_q[wr_addr_i[SLOT_W]])) begin
        fill_q[wr_addr_i[SLOT_W]] <= wr_idx + NS_W'(1);
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_word_q : WORD_EMPTY;

endmodule

// File: src/fee_datapath.sv
// Datapath: headers, slot pointer, key registers, slot scanner and result register.
// Depends on fee_pkg and fee_store.
module fee_datapath import fee_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  req_t        req_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        done_o,
  output rsp_t        rsp_o
);

  req_t              item_q;
  logic [15:0]       key0_q, key1_q;
  logic [1:0][15:0]  hdr_q;
  logic [NS_W-1:0]   ns_q;
  logic              lk_hit_q;
  logic [15:0]       lk_val_q;
  logic              act_q, ph_q, fe_q, spage_q;
  logic [15:0]       skey_q;
  logic [SLOT_W-1:0] cnt_q;
  logic              done_q;
  rsp_t              rsp_q;

  logic [15:0]       sel_key, sel_val;
  logic [31:0]       rd_data;
  logic              rd_en, wr_en, in_range;
  logic [ADDR_W-1:0] rd_addr, prog_addr;
  logic              chk, match, at_end, scan_done;

  always_comb begin
    unique case (cmd_i.key_sel)
      KSEL_K0: sel_key = key0_q;
      KSEL_K1: sel_key = key1_q;
      default: sel_key = item_q.virt_key;
    endcase
    sel_val = (cmd_i.key_sel == KSEL_REQ) ? item_q.write_value : lk_val_q;
  end

  assign in_range  = (ns_q != '0) && (ns_q < NS_W'(SLOTS));
  assign prog_addr = {cmd_i.prog_page, ns_q[SLOT_W-1:0]};
  assign rd_en     = cmd_i.prog_rd | (act_q & ~ph_q);
  assign rd_addr   = cmd_i.prog_rd ? prog_addr : {spage_q, cnt_q};
  assign wr_en     = cmd_i.prog_wr & in_range;

  assign chk       = act_q & ph_q;
  assign match     = fe_q ? (rd_data == WORD_EMPTY) : (rd_data[15:0] == skey_q);
  assign at_end    = fe_q ? (cnt_q == SLOT_W'(SLOTS - 1)) : (cnt_q == SLOT_W'(1));
  assign scan_done = chk & (match | at_end);

  fee_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_data_o   (rd_data),
    .wr_en_i     (wr_en),
    .wr_addr_i   (prog_addr),
    .wr_data_i   (rd_data & {sel_val, sel_key}),
    .erase_i     (cmd_i.erase),
    .erase_page_i(cmd_i.erase_page)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= req_i;
    end
    if (cmd_i.scan_start) begin
      fe_q    <= cmd_i.scan_fe;
      spage_q <= cmd_i.scan_page;
      skey_q  <= sel_key;
    end
    if (scan_done && !fe_q) begin
      lk_val_q <= rd_data[31:16];
    end
    if (cmd_i.emit) begin
      rsp_q.read_value  <= (item_q.req_type == REQ_READ && lk_hit_q) ? lk_val_q : 16'h0000;
      rsp_q.found       <= (item_q.req_type == REQ_READ) && lk_hit_q;
      rsp_q.store_ready <= vp_exists(hdr_q[0], hdr_q[1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q   <= KEY0_RST;
      key1_q   <= KEY1_RST;
      hdr_q    <= {HDR_ERASED, HDR_ERASED};
      ns_q     <= '0;
      lk_hit_q <= 1'b0;
      act_q    <= 1'b0;
      ph_q     <= 1'b0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_KEY_0) key0_q <= cfg_data_i;
        else                        key1_q <= cfg_data_i;
      end
      if (cmd_i.erase) begin
        hdr_q[cmd_i.erase_page] <= HDR_ERASED;
      end
      if (cmd_i.hdr_we) begin
        hdr_q[cmd_i.hdr_page] <= hdr_q[cmd_i.hdr_page] & cmd_i.hdr_val;
      end
      if (cmd_i.accept) begin
        lk_hit_q <= 1'b0;
      end else if (scan_done && !fe_q) begin
        lk_hit_q <= match;
      end
      if (cmd_i.ns_clear) begin
        ns_q <= '0;
      end else if (scan_done && fe_q) begin
        ns_q <= match ? {1'b0, cnt_q} : '0;
      end else if (wr_en) begin
        ns_q <= ns_q + NS_W'(1);
      end
      // each slot: an address phase, then a compare phase
      if (cmd_i.scan_start) begin
        act_q <= 1'b1;
        ph_q  <= 1'b0;
        cnt_q <= cmd_i.scan_fe ? SLOT_W'(1) : SLOT_W'(SLOTS - 1);
      end else if (act_q) begin
        if (!ph_q) begin
          ph_q <= 1'b1;
        end else if (scan_done) begin
          act_q <= 1'b0;
        end else begin
          ph_q  <= 1'b0;
          cnt_q <= fe_q ? cnt_q + SLOT_W'(1) : cnt_q - SLOT_W'(1);
        end
      end
    end
  end

  assign sts_o.req_type  = item_q.req_type;
  assign sts_o.hdr_a     = hdr_q[0];
  assign sts_o.hdr_b     = hdr_q[1];
  assign sts_o.scan_done = scan_done;
  assign sts_o.scan_hit  = match;
  assign sts_o.ns_full   = ~in_range;
  assign sts_o.ns_zero   = (ns_q == '0);

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: src/fee_ctrl.sv
// Controller: sequences read, write, page transfer and mount over the datapath.
// Depends on fee_pkg.
module fee_ctrl import fee_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   ret_q, ret_d;     // 1: transfer returns to the mount tail
  logic   newp_q, newp_d;
  logic   cur_q, cur_d;
  logic   kidx_q, kidx_d;

  logic [15:0] ha, hb;
  logic        vpe, vpp, last_key;

  assign ha       = sts_i.hdr_a;
  assign hb       = sts_i.hdr_b;
  assign vpe      = vp_exists(ha, hb);
  assign vpp      = vp_page(ha, hb);
  assign last_key = (kidx_q == 1'(NUM_KEYS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= 1'b0;
      newp_q  <= 1'b0;
      cur_q   <= 1'b0;
      kidx_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      newp_q  <= newp_d;
      cur_q   <= cur_d;
      kidx_q  <= kidx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    newp_d  = newp_q;
    cur_d   = cur_q;
    kidx_d  = kidx_q;
    cmd_o   = '0;
    cmd_o.key_sel = KSEL_REQ;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (req_e'(sts_i.req_type))
          REQ_READ: begin
            if (vpe) begin
              cmd_o.scan_start = 1'b1;
              cmd_o.scan_page  = vpp;
              state_d          = ST_RD_WAIT;
            end else begin
              state_d = ST_DONE;
            end
          end
          REQ_WRITE: begin
            cur_d   = vpp;
            state_d = vpe ? ST_W_RD : ST_DONE;
          end
          REQ_MOUNT: state_d = ST_M_CASE;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_RD_WAIT: begin
        if (sts_i.scan_done) state_d = ST_DONE;
      end
      ST_W_RD: begin
        cmd_o.prog_rd   = 1'b1;
        cmd_o.prog_page = cur_q;
        state_d         = ST_W_WR;
      end
      ST_W_WR: begin
        cmd_o.prog_wr   = 1'b1;
        cmd_o.prog_page = cur_q;
        state_d         = ST_W_CHK;
      end
      ST_W_CHK: begin
        ret_d   = 1'b0;
        state_d = sts_i.ns_full ? ST_X_INIT : ST_DONE;
      end
      ST_X_INIT: begin
        newp_d           = !((ha != HDR_VALID) && (hb == HDR_VALID));
        cmd_o.scan_start = 1'b1;
        cmd_o.scan_fe    = 1'b1;
        cmd_o.scan_page  = newp_d;
        state_d          = ST_X_FE_WAIT;
      end
      ST_X_FE_WAIT: begin
        if (sts_i.scan_done) state_d = ST_X_HDR;
      end
      ST_X_HDR: begin
        cmd_o.hdr_we   = 1'b1;
        cmd_o.hdr_page = newp_q;
        cmd_o.hdr_val  = HDR_XFER;
        kidx_d         = 1'b0;
        state_d        = ST_X_LK;
      end
      ST_X_LK: begin
        cmd_o.key_sel = kidx_q ? KSEL_K1 : KSEL_K0;
        if (vpe) begin
          cmd_o.scan_start = 1'b1;
          cmd_o.scan_page  = vpp;
          state_d          = ST_X_LK_WAIT;
        end else if (last_key) begin
          state_d = ST_X_ERASE;
        end else begin
          kidx_d = 1'b1;
        end
      end
      ST_X_LK_WAIT: begin
        if (sts_i.scan_done) begin
          if (sts_i.scan_hit) begin
            state_d = ST_X_P_RD;
          end else if (last_key) begin
            state_d = ST_X_ERASE;
          end else begin
            kidx_d  = 1'b1;
            state_d = ST_X_LK;
          end
        end
      end
      ST_X_P_RD: begin
        cmd_o.key_sel   = kidx_q ? KSEL_K1 : KSEL_K0;
        cmd_o.prog_rd   = 1'b1;
        cmd_o.prog_page = newp_q;
        state_d         = ST_X_P_WR;
      end
      ST_X_P_WR: begin
        cmd_o.key_sel   = kidx_q ? KSEL_K1 : KSEL_K0;
        cmd_o.prog_wr   = 1'b1;
        cmd_o.prog_page = newp_q;
        if (last_key) begin
          state_d = ST_X_ERASE;
        end else begin
          kidx_d  = 1'b1;
          state_d = ST_X_LK;
        end
      end
      ST_X_ERASE: begin
        cmd_o.erase      = 1'b1;
        cmd_o.erase_page = ~newp_q;
        state_d          = ST_X_VALID;
      end
      ST_X_VALID: begin
        cmd_o.hdr_we   = 1'b1;
        cmd_o.hdr_page = newp_q;
        cmd_o.hdr_val  = HDR_VALID;
        state_d        = ret_q ? ST_M_TAIL : ST_DONE;
      end
      ST_M_CASE: begin
        priority if (ha == HDR_VALID && hb == HDR_ERASED) begin
          cmd_o.erase      = 1'b1;
          cmd_o.erase_page = 1'b1;
          state_d          = ST_M_TAIL;
        end else if (ha == HDR_ERASED && hb == HDR_VALID) begin
          cmd_o.erase = 1'b1;
          state_d     = ST_M_TAIL;
        end else if (ha == HDR_ERASED && hb == HDR_XFER) begin
          cmd_o.erase = 1'b1;
          cur_d       = 1'b1;
          state_d     = ST_M_HDR;
        end else if (ha == HDR_XFER && hb == HDR_ERASED) begin
          cmd_o.erase      = 1'b1;
          cmd_o.erase_page = 1'b1;
          cur_d            = 1'b0;
          state_d          = ST_M_HDR;
        end else if ((ha == HDR_VALID && hb == HDR_XFER) ||
                     (ha == HDR_XFER && hb == HDR_VALID)) begin
          ret_d   = 1'b1;
          state_d = ST_X_INIT;
        end else begin
          cmd_o.erase = 1'b1;
          state_d     = ST_M_FMT;
        end
      end
      ST_M_FMT: begin
        cmd_o.erase      = 1'b1;
        cmd_o.erase_page = 1'b1;
        cur_d            = 1'b0;
        state_d          = ST_M_HDR;
      end
      ST_M_HDR: begin
        cmd_o.hdr_we   = 1'b1;
        cmd_o.hdr_page = cur_q;
        cmd_o.hdr_val  = HDR_VALID;
        state_d        = ST_M_TAIL;
      end
      ST_M_TAIL: begin
        if (vpe) begin
          cmd_o.scan_start = 1'b1;
          cmd_o.scan_fe    = 1'b1;
          cmd_o.scan_page  = vpp;
          state_d          = ST_M_FE_WAIT;
        end else begin
          cmd_o.ns_clear = 1'b1;
          state_d        = ST_M_CHK;
        end
      end
      ST_M_FE_WAIT: begin
        if (sts_i.scan_done) state_d = ST_M_CHK;
      end
      ST_M_CHK: begin
        ret_d   = 1'b0;
        state_d = sts_i.ns_zero ? ST_X_INIT : ST_DONE;
      end
      ST_DONE: begin
        cmd_o.emit = 1'b1;
        state_d    = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule
